### design/prr_pkg.sv
`default_nettype none
package prr_pkg;

  localparam int unsigned MaxElems   = 8;
  localparam int unsigned ElemW      = 3;
  localparam int unsigned RankW      = 16;
  localparam int unsigned RecipShift = 20;
  localparam int unsigned RecipW     = RecipShift + 1;
  localparam int unsigned ProdW      = RankW + RecipW;
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned DefElementCount = 8;

  typedef enum logic [1:0] {
    MODE_FULL_RANK   = 2'd0,
    MODE_FULL_UNRANK = 2'd1,
    MODE_EVEN_RANK   = 2'd2,
    MODE_EVEN_UNRANK = 2'd3
  } mode_e;

  typedef logic [ElemW-1:0] elem_t;
  typedef elem_t [MaxElems-1:0] elem_vec_t;

  typedef struct packed {
    logic [1:0]       mode;
    logic [RankW-1:0] rank_in;
    elem_t            perm_0;
    elem_t            perm_1;
    elem_t            perm_2;
    elem_t            perm_3;
    elem_t            perm_4;
    elem_t            perm_5;
    elem_t            perm_6;
    elem_t            perm_7;
  } in_t;

  typedef struct packed {
    logic             valid_res;
    logic [RankW-1:0] rank_out;
    elem_t            out_0;
    elem_t            out_1;
    elem_t            out_2;
    elem_t            out_3;
    elem_t            out_4;
    elem_t            out_5;
    elem_t            out_6;
    elem_t            out_7;
  } out_t;

  typedef struct packed {
    mode_e            mode;
    logic             ok;
    logic [RankW-1:0] r;
    elem_vec_t        dig;
  } job_t;

  function automatic logic [31:0] fact(input int unsigned v);
    logic [31:0] acc;
    acc = 32'd1;
    for (int unsigned k = 2; k <= MaxElems; k++) begin
      if (k <= v) begin
        acc = acc * 32'(k);
      end
    end
    return acc;
  endfunction

  // ceil(2^20 / d), exact quotient for 16-bit dividends
  function automatic logic [RecipW-1:0] recip(input int unsigned d);
    logic [RecipW-1:0] m;
    case (d)
      2: m = RecipW'(524288);
      3: m = RecipW'(349526);
      4: m = RecipW'(262144);
      5: m = RecipW'(209716);
      6: m = RecipW'(174763);
      7: m = RecipW'(149797);
      8: m = RecipW'(131072);
      default: m = RecipW'(1048576);
    endcase
    return m;
  endfunction

  function automatic elem_vec_t build_perm(input elem_vec_t dig, input int unsigned n);
    elem_vec_t pool;
    elem_vec_t res;
    elem_t     d;
    elem_t     cnt;
    res = '0;
    for (int unsigned i = 0; i < MaxElems; i++) begin
      pool[i] = ElemW'(i);
    end
    cnt = ElemW'(n - 1);
    for (int unsigned p = 0; p < MaxElems; p++) begin
      if (p < n) begin
        d = dig[p];
        if (d > cnt) begin
          d = cnt;
        end
        res[p] = pool[d];
        for (int unsigned k = 0; k < MaxElems - 1; k++) begin
          if (ElemW'(k) >= d) begin
            pool[k] = pool[k+1];
          end
        end
        cnt = cnt - ElemW'(1);
      end
    end
    return res;
  endfunction

endpackage
`default_nettype wire

### design/permutation_rank_unrank.sv
// Lehmer-code rank/unrank of a permutation of ELEMENT_COUNT elements. One
// transaction is accepted per cycle while the queue is not full, and each gives
// exactly one result transaction, in order: the front decodes the mode, checks
// elements and range and forms rank-mode digits in the accept cycle, a
// two-entry queue decouples it from the back, whose pipeline peels at most one
// mixed-radix digit per stage by a reciprocal multiply in unrank modes and then
// forms the rank or the permutation into the output register.
`default_nettype none
module permutation_rank_unrank #(
  parameter int unsigned ELEMENT_COUNT = prr_pkg::DefElementCount
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  prr_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output prr_pkg::out_t out_data_o
);
  import prr_pkg::*;

  job_t front_job;
  job_t head_job;
  logic full, empty, pop;

  assign in_stall_o = full;

  prr_front #(.ELEMENT_COUNT(ELEMENT_COUNT)) u_front (
    .in_data_i (in_data_i),
    .job_o     (front_job)
  );

  prr_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_valid_i),
    .push_data_i (front_job),
    .full_o      (full),
    .pop_i       (pop),
    .empty_o     (empty),
    .pop_data_o  (head_job)
  );

  prr_back #(.ELEMENT_COUNT(ELEMENT_COUNT)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (!empty),
    .job_i       (head_job),
    .job_pop_o   (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
`default_nettype wire

### design/prr_front.sv
`default_nettype none
module prr_front #(
  parameter int unsigned ELEMENT_COUNT = prr_pkg::DefElementCount
) (
  input  prr_pkg::in_t  in_data_i,
  output prr_pkg::job_t job_o
);
  import prr_pkg::*;

  localparam logic [31:0] FullCount = fact(ELEMENT_COUNT);
  localparam logic [31:0] HalfCount = FullCount / 2;

  elem_vec_t p;
  elem_vec_t dig;
  logic      uniq;
  logic      par;
  mode_e     mode;

  assign p = {in_data_i.perm_7, in_data_i.perm_6, in_data_i.perm_5, in_data_i.perm_4,
              in_data_i.perm_3, in_data_i.perm_2, in_data_i.perm_1, in_data_i.perm_0};
  assign mode = mode_e'(in_data_i.mode);

  always_comb begin
    uniq = 1'b1;
    par  = 1'b0;
    dig  = '0;
    for (int unsigned i = 0; i < MaxElems; i++) begin
      if (i < ELEMENT_COUNT) begin
        if (32'(p[i]) >= ELEMENT_COUNT) begin
          uniq = 1'b0;
        end
        for (int unsigned j = 0; j < MaxElems; j++) begin
          if (j > i && j < ELEMENT_COUNT) begin
            if (p[j] == p[i]) begin
              uniq = 1'b0;
            end
            if (p[j] < p[i]) begin
              dig[i] = dig[i] + ElemW'(1);
            end
          end
        end
      end
    end
    for (int unsigned i = 0; i < MaxElems; i++) begin
      par = par ^ dig[i][0];
    end
  end

  always_comb begin
    job_o.mode = mode;
    job_o.r    = in_data_i.rank_in;
    job_o.dig  = '0;
    job_o.ok   = 1'b0;
    case (mode)
      MODE_FULL_RANK: begin
        job_o.ok  = uniq;
        job_o.dig = dig;
      end
      MODE_EVEN_RANK: begin
        job_o.ok  = uniq && !par;
        job_o.dig = dig;
      end
      MODE_FULL_UNRANK: begin
        job_o.ok = 32'(in_data_i.rank_in) < FullCount;
      end
      MODE_EVEN_UNRANK: begin
        job_o.ok = 32'(in_data_i.rank_in) < HalfCount;
      end
      default: begin
        job_o.ok = 1'b0;
      end
    endcase
  end

endmodule
`default_nettype wire

### design/prr_queue.sv
`default_nettype none
module prr_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  prr_pkg::job_t push_data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output prr_pkg::job_t pop_data_o
);
  import prr_pkg::*;

  localparam int unsigned PtrW = $clog2(QueueDepth);
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  job_t            mem_q [QueueDepth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o     = cnt_q == CntW'(QueueDepth);
  assign empty_o    = cnt_q == '0;
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (32'(wr_q) == QueueDepth - 1) ? '0 : wr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_d = (32'(rd_q) == QueueDepth - 1) ? '0 : rd_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule
`default_nettype wire

### design/prr_back.sv
`default_nettype none
module prr_back #(
  parameter int unsigned ELEMENT_COUNT = prr_pkg::DefElementCount
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          job_valid_i,
  input  prr_pkg::job_t job_i,
  output logic          job_pop_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output prr_pkg::out_t out_data_o
);
  import prr_pkg::*;

  localparam int unsigned N = ELEMENT_COUNT;

  job_t                   st_q [N+1];
  job_t                   nxt [N];
  logic [N:0]             vld_q;
  logic [N-1:0][ProdW-1:0] prod;
  logic [N-1:0][RankW-1:0] quo;
  logic [N-1:0][RankW-1:0] rem;
  logic                   adv;
  logic                   out_vld_q;
  out_t                   out_q, out_d;
  job_t                   fin;
  elem_vec_t              d;
  elem_vec_t              perm;
  logic [RankW-1:0]       rank;
  logic                   par;

  assign adv         = !(out_vld_q && out_stall_i);
  assign job_pop_o   = adv && job_valid_i;
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  // in unrank modes, stage s peels off the digit at position n-1-s, radix s+1 (even unrank: s >= 2 only)
  always_comb begin
    for (int unsigned s = 0; s < N; s++) begin
      nxt[s]  = st_q[s];
      prod[s] = ProdW'(st_q[s].r) * ProdW'(recip(s + 1));
      quo[s]  = prod[s][RecipShift +: RankW];
      rem[s]  = st_q[s].r - RankW'(quo[s] * RankW'(s + 1));
      if (st_q[s].mode == MODE_FULL_UNRANK ||
          (st_q[s].mode == MODE_EVEN_UNRANK && s >= 2)) begin
        nxt[s].dig[N-1-s] = rem[s][ElemW-1:0];
        nxt[s].r          = quo[s];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      vld_q     <= {vld_q[N-1:0], job_valid_i};
      out_vld_q <= vld_q[N];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      st_q[0] <= job_i;
      for (int unsigned s = 0; s < N; s++) begin
        st_q[s+1] <= nxt[s];
      end
      out_q <= out_d;
    end
  end

  always_comb begin
    fin  = st_q[N];
    d    = fin.dig;
    par  = 1'b0;
    rank = '0;
    for (int unsigned i = 0; i < MaxElems; i++) begin
      if (i + 2 < N) begin
        par = par ^ d[i][0];
      end
    end
    for (int unsigned i = 0; i < MaxElems; i++) begin
      if (i < N) begin
        if (fin.mode == MODE_FULL_RANK) begin
          rank = rank + RankW'(RankW'(d[i]) * RankW'(fact(N - 1 - i)));
        end else if (i + 2 < N) begin
          rank = rank + RankW'(RankW'(d[i]) * RankW'(fact(N - 1 - i) >> 1));
        end
      end
    end
    if (fin.mode == MODE_EVEN_UNRANK) begin
      d[N-2] = {{(ElemW-1){1'b0}}, par};
    end
    perm  = build_perm(d, N);
    out_d = '0;
    if (fin.ok) begin
      out_d.valid_res = 1'b1;
      case (fin.mode)
        MODE_FULL_RANK, MODE_EVEN_RANK: begin
          out_d.rank_out = rank;
        end
        MODE_FULL_UNRANK, MODE_EVEN_UNRANK: begin
          out_d.out_0 = perm[0];
          out_d.out_1 = perm[1];
          out_d.out_2 = perm[2];
          out_d.out_3 = perm[3];
          out_d.out_4 = perm[4];
          out_d.out_5 = perm[5];
          out_d.out_6 = perm[6];
          out_d.out_7 = perm[7];
        end
        default: begin
          out_d = '0;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

### design/prr_checker.sv
`default_nettype none
module prr_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_stall_o,
  input logic          out_valid_o,
  input logic          out_stall_i,
  input prr_pkg::out_t out_data_o
);
  import prr_pkg::*;

  logic outs_zero;
  assign outs_zero = out_data_o.out_0 == '0 && out_data_o.out_1 == '0 &&
                     out_data_o.out_2 == '0 && out_data_o.out_3 == '0 &&
                     out_data_o.out_4 == '0 && out_data_o.out_5 == '0 &&
                     out_data_o.out_6 == '0 && out_data_o.out_7 == '0;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.valid_res |-> out_data_o.rank_out == '0 && outs_zero)
    else $error("invalid result not zeroed");

  a_rank_no_perm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.rank_out != '0 |-> out_data_o.valid_res && outs_zero)
    else $error("rank result carries a permutation");

  a_rank_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.rank_out < 16'd40320)
    else $error("rank out of range");

  a_idle_no_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_valid_i && !out_valid_o && !$past(in_valid_i) |=> !in_stall_o || in_valid_i)
    else $error("input stalled with nothing in flight");

endmodule

bind permutation_rank_unrank prr_checker u_prr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
`default_nettype wire

### tb/sv/permutation_rank_unrank_checker.sv
`timescale 1ns / 100ps
`default_nettype none
module permutation_rank_unrank_checker (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_stall_i,
  input  prr_pkg::in_t  in_data_i,
  input  logic          out_valid_i,
  input  logic          out_stall_i,
  input  prr_pkg::out_t out_data_i,
  output int            fail_count_o,
  output int            pending_o
);
  import prr_pkg::*;

  out_t expected_q[$];

  function automatic int unsigned factorial(input int unsigned v);
    int unsigned r;
    r = 1;
    for (int unsigned k = 2; k <= v; k++) begin
      r = r * k;
    end
    return r;
  endfunction

  function automatic out_t predict_result(input in_t t);
    out_t res;
    int unsigned n;
    int unsigned pool[8];
    int unsigned digs[8];
    int unsigned elems[8];
    int unsigned cnt;
    int unsigned d;
    int unsigned par;
    int unsigned rank;
    int unsigned lim;
    int unsigned r;
    int unsigned radix;
    mode_e m;
    res = '0;
    n = 8;
    m = mode_e'(t.mode);
    elems = '{t.perm_0, t.perm_1, t.perm_2, t.perm_3, t.perm_4, t.perm_5, t.perm_6, t.perm_7};
    digs = '{default: 0};
    for (int i = 0; i < 8; i++) begin
      pool[i] = i;
    end
    cnt = n;
    if (m == MODE_FULL_RANK || m == MODE_EVEN_RANK) begin
      for (int p = 0; p < n; p++) begin
        d = 0;
        while (d < cnt && pool[d] != elems[p]) begin
          d++;
        end
        if (d == cnt) begin
          return res;
        end
        digs[p] = d;
        for (int k = d; k + 1 < cnt; k++) begin
          pool[k] = pool[k+1];
        end
        cnt--;
      end
      lim = (m == MODE_FULL_RANK) ? n : n - 2;
      par = 0;
      rank = 0;
      for (int i = 0; i < n; i++) begin
        par += digs[i];
        if (i < lim) begin
          rank = rank * (n - i) + digs[i];
        end
      end
      if (m == MODE_EVEN_RANK && par[0]) begin
        return res;
      end
      res.valid_res = 1'b1;
      res.rank_out = rank[15:0];
      return res;
    end
    r = t.rank_in;
    if (m == MODE_FULL_UNRANK) begin
      if (r >= factorial(n)) begin
        return res;
      end
      for (int i = n; i > 0; i--) begin
        radix = n - (i - 1);
        digs[i-1] = r % radix;
        r = r / radix;
      end
    end else begin
      if (r >= factorial(n) / 2) begin
        return res;
      end
      par = 0;
      for (int i = n - 2; i > 0; i--) begin
        radix = n - (i - 1);
        digs[i-1] = r % radix;
        r = r / radix;
        par += digs[i-1];
      end
      digs[n-2] = par & 1;
      digs[n-1] = 0;
    end
    for (int p = 0; p < n; p++) begin
      d = digs[p];
      if (d >= cnt) begin
        d = cnt - 1;
      end
      elems[p] = pool[d];
      for (int k = d; k + 1 < cnt; k++) begin
        pool[k] = pool[k+1];
      end
      cnt--;
    end
    res.valid_res = 1'b1;
    res.out_0 = 3'(elems[0]);
    res.out_1 = 3'(elems[1]);
    res.out_2 = 3'(elems[2]);
    res.out_3 = 3'(elems[3]);
    res.out_4 = 3'(elems[4]);
    res.out_5 = 3'(elems[5]);
    res.out_6 = 3'(elems[6]);
    res.out_7 = 3'(elems[7]);
    return res;
  endfunction

  assign pending_o = expected_q.size();

  initial fail_count_o = 0;

  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_i) begin
        expected_q.push_back(predict_result(in_data_i));
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result %h", $time, out_data_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = expected_q.pop_front();
          if (want.valid_res !== out_data_i.valid_res || want.rank_out !== out_data_i.rank_out ||
              want.out_0 !== out_data_i.out_0 || want.out_1 !== out_data_i.out_1 ||
              want.out_2 !== out_data_i.out_2 || want.out_3 !== out_data_i.out_3 ||
              want.out_4 !== out_data_i.out_4 || want.out_5 !== out_data_i.out_5 ||
              want.out_6 !== out_data_i.out_6 || want.out_7 !== out_data_i.out_7) begin
            $display("%0t: mismatch expected %p actual %p", $time, want, out_data_i);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
  end
endmodule
`default_nettype wire

### tb/sv/permutation_rank_unrank_test.sv
`timescale 1ns / 100ps
`default_nettype none
module permutation_rank_unrank_test;
  import prr_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic out_stall_i = 1'b0;
  in_t  in_data_i = '0;
  logic in_stall_o;
  logic out_valid_o;
  out_t out_data_o;
  int   fail_count;
  int   pending;
  bit   hold_off = 1'b0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  permutation_rank_unrank dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o
  );

  permutation_rank_unrank_checker checker_i (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .in_data_i,
    .out_valid_i(out_valid_o), .out_stall_i, .out_data_i(out_data_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  function automatic in_t shuffled(input mode_e m);
    in_t t;
    logic [2:0] p[8];
    logic [2:0] tmp;
    int j;
    for (int i = 0; i < 8; i++) begin
      p[i] = 3'(i);
    end
    for (int i = 7; i > 0; i--) begin
      j = $urandom_range(i, 0);
      tmp = p[i];
      p[i] = p[j];
      p[j] = tmp;
    end
    t = in_t'($urandom());
    t.rank_in = 16'($urandom());
    t.mode = m;
    {t.perm_0, t.perm_1, t.perm_2, t.perm_3, t.perm_4, t.perm_5, t.perm_6, t.perm_7} =
      {p[0], p[1], p[2], p[3], p[4], p[5], p[6], p[7]};
    return t;
  endfunction

  task automatic send(input in_t t);
    in_valid_i <= 1'b1;
    in_data_i <= t;
    @(posedge clk_i);
    while (in_stall_o) begin
      @(posedge clk_i);
    end
  endtask

  task automatic idle(input int n);
    in_valid_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  function automatic in_t random_item();
    in_t t;
    int k;
    mode_e m;
    m = mode_e'($urandom_range(3, 0));
    t = shuffled(m);
    k = $urandom_range(9, 0);
    if (m == MODE_FULL_UNRANK) begin
      t.rank_in = 16'((k < 8) ? $urandom_range(40319, 0) : $urandom_range(65535, 40320));
    end else if (m == MODE_EVEN_UNRANK) begin
      t.rank_in = 16'((k < 8) ? $urandom_range(20159, 0) : $urandom_range(65535, 20160));
    end else if (k >= 8) begin
      t.perm_3 = 3'($urandom());
      t.perm_6 = 3'($urandom());
    end
    return t;
  endfunction

  initial begin
    in_t t;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // directed
    for (int m = 0; m < 4; m++) begin
      t = '0;
      t.mode = 2'(m);
      {t.perm_0, t.perm_1, t.perm_2, t.perm_3, t.perm_4, t.perm_5, t.perm_6, t.perm_7} =
        {3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6, 3'd7};
      send(t);
      {t.perm_0, t.perm_1, t.perm_2, t.perm_3, t.perm_4, t.perm_5, t.perm_6, t.perm_7} =
        {3'd7, 3'd6, 3'd5, 3'd4, 3'd3, 3'd2, 3'd1, 3'd0};
      t.rank_in = 16'hFFFF;
      send(t);
    end
    t = '0;
    t.mode = MODE_FULL_RANK;
    send(t);
    t.mode = MODE_EVEN_RANK;
    send(t);
    t = shuffled(MODE_EVEN_RANK);
    {t.perm_0, t.perm_1} = {3'd1, 3'd0};
    {t.perm_2, t.perm_3, t.perm_4, t.perm_5, t.perm_6, t.perm_7} =
      {3'd2, 3'd3, 3'd4, 3'd5, 3'd6, 3'd7};
    send(t);
    t.mode = MODE_FULL_UNRANK;
    t.rank_in = 16'd40319;
    send(t);
    t.rank_in = 16'd40320;
    send(t);
    t.mode = MODE_EVEN_UNRANK;
    t.rank_in = 16'd20159;
    send(t);
    t.rank_in = 16'd20160;
    send(t);
    t.rank_in = 16'd0;
    send(t);
    // pause until drained
    in_valid_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    // long output hold-off while offering items
    hold_off <= 1'b1;
    repeat (40) send(random_item());
    // bursts with gaps
    for (int n = 0; n < 860; ) begin
      int b;
      b = $urandom_range(20, 1);
      repeat (b) send(random_item());
      n += b;
      if ($urandom_range(3, 0) != 0) begin
        idle($urandom_range(6, 1));
      end
    end
    in_valid_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("** permutation_rank_unrank: PASSED **");
    end else begin
      $display("** permutation_rank_unrank: FAILED **");
    end
    $finish;
  end

  initial begin
    int cnt;
    wait (hold_off);
    @(posedge clk_i);
    out_stall_i <= 1'b1;
    repeat (60) @(posedge clk_i);
    forever begin
      cnt = $urandom_range(30, 1);
      if ($urandom_range(2, 0) == 0) begin
        out_stall_i <= 1'b0;
        repeat (cnt) @(posedge clk_i);
      end else begin
        repeat (cnt) begin
          out_stall_i <= ($urandom_range(2, 0) == 0);
          @(posedge clk_i);
        end
      end
    end
  end

  initial begin
    #400000;
    $display("** permutation_rank_unrank: FAILED **");
    $finish;
  end
endmodule
`default_nettype wire

### sim.f
design/prr_pkg.sv
design/prr_front.sv
design/prr_queue.sv
design/prr_back.sv
design/permutation_rank_unrank.sv
design/prr_checker.sv
tb/sv/permutation_rank_unrank_checker.sv
tb/sv/permutation_rank_unrank_test.sv
